### rtl/ste_pkg.sv
`timescale 1ns / 1ps
package ste_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int FRACTION_BITS = 16;
  localparam int ACC_WIDTH = 64;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int THRESHOLD_WIDTH = 32;
  localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 32'd168;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELTA_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELTA_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELTA_Z = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD = 3'd6;

  typedef enum logic [1:0] {
    FRAC_ZERO,
    FRAC_ONE,
    FRAC_DIV
  } frac_sel_t;

endpackage

### rtl/ste_geometry.sv
`timescale 1ns / 1ps
module ste_geometry #(
  parameter int COORD_WIDTH = ste_pkg::COORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  logic signed [COORD_WIDTH-1:0] va [3],
  input  logic signed [COORD_WIDTH-1:0] vb [3],
  input  logic signed [COORD_WIDTH-1:0] vc [3],
  input  logic signed [COORD_WIDTH-1:0] org [3],
  input  logic signed [COORD_WIDTH-1:0] dlt [3],
  output logic out_v,
  output logic signed [ste_pkg::ACC_WIDTH-1:0] det,
  output logic signed [ste_pkg::ACC_WIDTH-1:0] un,
  output logic signed [ste_pkg::ACC_WIDTH-1:0] vn,
  output logic signed [ste_pkg::ACC_WIDTH-1:0] tn
);
  localparam int AW = ste_pkg::ACC_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int L = XW / 2;
  localparam int HW = XW - L;

  logic [3:0] v;

  // stage 1: edges and origin offset
  logic signed [DW-1:0] e1_1 [3], e2_1 [3], s_1 [3], dl_1 [3];
  // stage 2: cross product terms
  logic signed [PW-1:0] pa_2 [3], pb_2 [3], qa_2 [3], qb_2 [3];
  logic signed [DW-1:0] e1_2 [3], e2_2 [3], s_2 [3], dl_2 [3];
  // stage 3: cross products
  logic signed [XW-1:0] p_3 [3], q_3 [3];
  logic signed [DW-1:0] e1_3 [3], e2_3 [3], s_3 [3], dl_3 [3];
  // stage 4: dot product partials, high and low halves
  logic signed [DW+HW-1:0] hd_4 [3], hu_4 [3], hv_4 [3], ht_4 [3];
  logic signed [DW+L:0] ld_4 [3], lu_4 [3], lv_4 [3], lt_4 [3];

  logic signed [HW-1:0] p_hi [3], q_hi [3];
  logic signed [L:0] p_lo [3], q_lo [3];
  logic signed [AW-1:0] td [3], tu [3], tv [3], tt [3];

  for (genvar i = 0; i < 3; i++) begin : g_split
    assign p_hi[i] = p_3[i][XW-1:L];
    assign q_hi[i] = q_3[i][XW-1:L];
    assign p_lo[i] = $signed({1'b0, p_3[i][L-1:0]});
    assign q_lo[i] = $signed({1'b0, q_3[i][L-1:0]});
    assign td[i] = (AW'(hd_4[i]) <<< L) + AW'(ld_4[i]);
    assign tu[i] = (AW'(hu_4[i]) <<< L) + AW'(lu_4[i]);
    assign tv[i] = (AW'(hv_4[i]) <<< L) + AW'(lv_4[i]);
    assign tt[i] = (AW'(ht_4[i]) <<< L) + AW'(lt_4[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v <= {v[2:0], in_v};
      out_v <= v[3];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        e1_1[i] <= DW'(vb[i]) - DW'(va[i]);
        e2_1[i] <= DW'(vc[i]) - DW'(va[i]);
        s_1[i] <= DW'(org[i]) - DW'(va[i]);
        dl_1[i] <= DW'(dlt[i]);

        pa_2[i] <= dl_1[I1] * e2_1[I2];
        pb_2[i] <= dl_1[I2] * e2_1[I1];
        qa_2[i] <= s_1[I1] * e1_1[I2];
        qb_2[i] <= s_1[I2] * e1_1[I1];
        e1_2[i] <= e1_1[i];
        e2_2[i] <= e2_1[i];
        s_2[i] <= s_1[i];
        dl_2[i] <= dl_1[i];

        p_3[i] <= XW'(pa_2[i]) - XW'(pb_2[i]);
        q_3[i] <= XW'(qa_2[i]) - XW'(qb_2[i]);
        e1_3[i] <= e1_2[i];
        e2_3[i] <= e2_2[i];
        s_3[i] <= s_2[i];
        dl_3[i] <= dl_2[i];

        hd_4[i] <= e1_3[i] * p_hi[i];
        ld_4[i] <= e1_3[i] * p_lo[i];
        hu_4[i] <= s_3[i] * p_hi[i];
        lu_4[i] <= s_3[i] * p_lo[i];
        hv_4[i] <= dl_3[i] * q_hi[i];
        lv_4[i] <= dl_3[i] * q_lo[i];
        ht_4[i] <= e2_3[i] * q_hi[i];
        lt_4[i] <= e2_3[i] * q_lo[i];
      end
    end
  end

  // stage 5: sums wrap at the accumulator width
  always_ff @(posedge clk) begin
    if (en) begin
      det <= td[0] + td[1] + td[2];
      un <= tu[0] + tu[1] + tu[2];
      vn <= tv[0] + tv[1] + tv[2];
      tn <= tt[0] + tt[1] + tt[2];
    end
  end

endmodule

### rtl/ste_divider.sv
`timescale 1ns / 1ps
module ste_divider #(
  parameter int FRACTION_BITS = ste_pkg::FRACTION_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  logic in_hit,
  input  ste_pkg::frac_sel_t in_sel,
  input  logic [ste_pkg::ACC_WIDTH-1:0] num,
  input  logic [ste_pkg::ACC_WIDTH-1:0] den,
  output logic out_v,
  output logic out_hit,
  output ste_pkg::frac_sel_t out_sel,
  output logic [FRACTION_BITS:0] quo
);
  localparam int AW = ste_pkg::ACC_WIDTH;
  localparam int N = FRACTION_BITS + 1;

  logic [AW-1:0] r [N], d [N];
  logic [FRACTION_BITS:0] q [N];
  logic v [N], h [N];
  ste_pkg::frac_sel_t sel [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [AW-1:0] r_in, d_in, r2;
    logic [FRACTION_BITS:0] q_in;
    logic v_in, h_in, ge;
    ste_pkg::frac_sel_t s_in;
    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign v_in = in_v;
      assign h_in = in_hit;
      assign s_in = in_sel;
    end else begin : g_next
      assign r_in = r[k-1];
      assign d_in = d[k-1];
      assign q_in = q[k-1];
      assign v_in = v[k-1];
      assign h_in = h[k-1];
      assign s_in = sel[k-1];
    end
    // the shift drops the top bit of the remainder
    assign r2 = {r_in[AW-2:0], 1'b0};
    assign ge = r2 >= d_in;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r[k] <= ge ? r2 - d_in : r2;
        d[k] <= d_in;
        q[k] <= {q_in[FRACTION_BITS-1:0], ge};
        h[k] <= h_in;
        sel[k] <= s_in;
      end
    end
  end

  assign out_v = v[N-1];
  assign out_hit = h[N-1];
  assign out_sel = sel[N-1];
  assign quo = q[N-1];

endmodule

### rtl/segment_triangle_intersect.sv
`timescale 1ns / 1ps
// segment versus triangle test, one triangle item per cycle unless stalled
// load origin, delta and parallel threshold through the cfg write port
// (cfg_we, cfg_index, cfg_data) while no item is in flight
// triangle items enter on in_valid/in_ready, one result item leaves on
// out_valid/out_ready for every triangle, in order
// the pipeline is five stages of edge, cross and dot products, two
// classification stages, a restoring divider with one quotient bit per
// stage, and the output register
// throughput is one item per cycle; the whole pipeline advances together,
// so in_ready is low only while a result waits and out_ready is low
// a stalled pipeline holds every stage, nothing is lost or repeated
// synchronous reset empties the pipeline and sets origin and delta to zero,
// threshold to 168
module segment_triangle_intersect #(
  parameter int COORD_WIDTH = ste_pkg::COORD_WIDTH,
  parameter int FRACTION_BITS = ste_pkg::FRACTION_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic [FRACTION_BITS:0] hit_fraction,
  input  logic cfg_we,
  input  logic [ste_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ste_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  localparam int AW = ste_pkg::ACC_WIDTH;

  logic signed [COORD_WIDTH-1:0] org [3], dlt [3], va [3], vb [3], vc [3];
  logic [ste_pkg::THRESHOLD_WIDTH-1:0] threshold;
  logic adv;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  assign va[0] = vertex_a_x;
  assign va[1] = vertex_a_y;
  assign va[2] = vertex_a_z;
  assign vb[0] = vertex_b_x;
  assign vb[1] = vertex_b_y;
  assign vb[2] = vertex_b_z;
  assign vc[0] = vertex_c_x;
  assign vc[1] = vertex_c_y;
  assign vc[2] = vertex_c_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dlt[0] <= '0;
      dlt[1] <= '0;
      dlt[2] <= '0;
      threshold <= ste_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ste_pkg::REG_ORIGIN_X: org[0] <= cfg_data[COORD_WIDTH-1:0];
        ste_pkg::REG_ORIGIN_Y: org[1] <= cfg_data[COORD_WIDTH-1:0];
        ste_pkg::REG_ORIGIN_Z: org[2] <= cfg_data[COORD_WIDTH-1:0];
        ste_pkg::REG_DELTA_X: dlt[0] <= cfg_data[COORD_WIDTH-1:0];
        ste_pkg::REG_DELTA_Y: dlt[1] <= cfg_data[COORD_WIDTH-1:0];
        ste_pkg::REG_DELTA_Z: dlt[2] <= cfg_data[COORD_WIDTH-1:0];
        ste_pkg::REG_THRESHOLD: threshold <= cfg_data[ste_pkg::THRESHOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic g_v;
  logic signed [AW-1:0] g_det, g_un, g_vn, g_tn;

  ste_geometry #(.COORD_WIDTH(COORD_WIDTH)) u_geometry (
    .clk(clk), .rst(rst), .en(adv), .in_v(in_valid),
    .va(va), .vb(vb), .vc(vc), .org(org), .dlt(dlt),
    .out_v(g_v), .det(g_det), .un(g_un), .vn(g_vn), .tn(g_tn)
  );

  // stage 6: magnitude, sign fold, tolerance bounds
  logic v6;
  logic [AW-1:0] d6;
  logic signed [AW-1:0] un6, vn6, tn6, uv6, lo6, hi6;
  logic [AW-1:0] d_abs, e_tol;
  logic signed [AW-1:0] un_f, vn_f;

  assign d_abs = g_det[AW-1] ? AW'(0) - g_det : g_det;
  assign e_tol = d_abs >> FRACTION_BITS;
  assign un_f = g_det[AW-1] ? AW'(0) - g_un : g_un;
  assign vn_f = g_det[AW-1] ? AW'(0) - g_vn : g_vn;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d6 <= d_abs;
      un6 <= un_f;
      vn6 <= vn_f;
      tn6 <= g_det[AW-1] ? AW'(0) - g_tn : g_tn;
      uv6 <= un_f + vn_f;
      lo6 <= AW'(0) - e_tol;
      hi6 <= d_abs + e_tol;
    end
  end

  // stage 7: accept or reject, pick the fraction source
  logic v7, hit7, miss;
  ste_pkg::frac_sel_t sel7, sel_next;
  logic [AW-1:0] num7, d7;

  assign miss = (d6 <= AW'(threshold)) || (un6 < lo6) || (un6 > hi6) || (vn6 < lo6)
    || (uv6 > hi6) || (tn6 < lo6) || (tn6 > hi6);

  always_comb begin
    if (tn6 <= 0) begin
      sel_next = ste_pkg::FRAC_ZERO;
    end else if (tn6 >= d6) begin
      sel_next = ste_pkg::FRAC_ONE;
    end else begin
      sel_next = ste_pkg::FRAC_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit7 <= !miss;
      sel7 <= sel_next;
      num7 <= tn6;
      d7 <= d6;
    end
  end

  logic dv_v, dv_hit;
  ste_pkg::frac_sel_t dv_sel;
  logic [FRACTION_BITS:0] dv_quo;
  logic [FRACTION_BITS+1:0] rounded;
  logic [FRACTION_BITS:0] frac_next;

  ste_divider #(.FRACTION_BITS(FRACTION_BITS)) u_divider (
    .clk(clk), .rst(rst), .en(adv), .in_v(v7), .in_hit(hit7), .in_sel(sel7),
    .num(num7), .den(d7), .out_v(dv_v), .out_hit(dv_hit), .out_sel(dv_sel),
    .quo(dv_quo)
  );

  // one extra quotient bit, round half up
  assign rounded = ({1'b0, dv_quo} + (FRACTION_BITS + 2)'(1)) >> 1;

  always_comb begin
    frac_next = '0;
    if (dv_hit) begin
      case (dv_sel)
        ste_pkg::FRAC_ONE: frac_next = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
        ste_pkg::FRAC_DIV: frac_next = rounded[FRACTION_BITS:0];
        default: frac_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= dv_hit;
      hit_fraction <= frac_next;
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_fraction == '0)
    else $error("miss with nonzero fraction");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_fraction <= ((FRACTION_BITS + 1)'(1) << FRACTION_BITS))
    else $error("fraction above one");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule
